>>> hw/rtl/sasb_pkg.sv
package sasb_pkg;

    localparam int MAX_SPRITE_W  = 64;
    localparam int MAX_SPRITE_H  = 64;
    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;

    localparam int STORE_DEPTH = MAX_SPRITE_W * MAX_SPRITE_H;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int PIX_W   = 32;
    localparam int IDX_W   = 12;
    localparam int OFS_W   = 9;
    localparam int POS_W   = 11;
    localparam int SCALE_W = 4;
    localparam int DIM_W   = 7;
    localparam int SCR_W   = 10;
    localparam int CH_W    = 8;
    localparam int MIX_W   = 2 * CH_W;
    localparam int SUM_W   = POS_W + 1;

    localparam int RECIP_SH  = OFS_W + SCALE_W;
    localparam int RECIP_W   = RECIP_SH + 1;
    localparam int PROD_W    = OFS_W + RECIP_W;
    localparam int RECIP_ONE = 1 << RECIP_SH;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = POS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd5;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DRAW = 1'b1;

    localparam logic [CH_W-1:0] OPAQUE_LIMIT = 8'd250;
    localparam logic [CH_W-1:0] ALPHA_FULL   = 8'hFF;
    localparam logic [CH_W-1:0] CH_MAX       = 8'd255;

    // ceil(2^RECIP_SH / s), exact quotient for every dest offset
    localparam logic [RECIP_W-1:0] RECIP_TAB [16] = '{
        '0,
        RECIP_W'((RECIP_ONE + 0) / 1),
        RECIP_W'((RECIP_ONE + 1) / 2),
        RECIP_W'((RECIP_ONE + 2) / 3),
        RECIP_W'((RECIP_ONE + 3) / 4),
        RECIP_W'((RECIP_ONE + 4) / 5),
        RECIP_W'((RECIP_ONE + 5) / 6),
        RECIP_W'((RECIP_ONE + 6) / 7),
        RECIP_W'((RECIP_ONE + 7) / 8),
        RECIP_W'((RECIP_ONE + 8) / 9),
        RECIP_W'((RECIP_ONE + 9) / 10),
        RECIP_W'((RECIP_ONE + 10) / 11),
        RECIP_W'((RECIP_ONE + 11) / 12),
        RECIP_W'((RECIP_ONE + 12) / 13),
        RECIP_W'((RECIP_ONE + 13) / 14),
        RECIP_W'((RECIP_ONE + 14) / 15)
    };

    typedef struct packed {
        logic [POS_W-1:0]   origin_x;
        logic [POS_W-1:0]   origin_y;
        logic [SCALE_W-1:0] scale_factor;
        logic               mirror;
        logic [DIM_W-1:0]   sprite_width;
        logic [DIM_W-1:0]   sprite_height;
    } cfg_t;

    typedef struct packed {
        logic             func;
        logic [IDX_W-1:0] pixel_index;
        logic [PIX_W-1:0] pixel_value;
        logic [OFS_W-1:0] dest_col;
        logic [OFS_W-1:0] dest_row;
        logic [PIX_W-1:0] screen_pixel;
    } req_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [PIX_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic             valid;
        logic             draw;
        logic [SCR_W-1:0] screen_col;
        logic [SCR_W-1:0] screen_row;
        logic [PIX_W-1:0] screen_pixel;
    } tag_t;

    function automatic logic [CH_W-1:0] div255(input logic [MIX_W-1:0] x);
        logic [MIX_W:0] t;
        t = (MIX_W + 1)'(x) + (MIX_W + 1)'(x >> CH_W) + (MIX_W + 1)'(1);
        return t[MIX_W-1:CH_W];
    endfunction

endpackage

>>> hw/rtl/sasb_if.sv
interface sasb_cmd_if
    import sasb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             func;
    logic [IDX_W-1:0] pixel_index;
    logic [PIX_W-1:0] pixel_value;
    logic [OFS_W-1:0] dest_col;
    logic [OFS_W-1:0] dest_row;
    logic [PIX_W-1:0] screen_pixel;

    modport source (
        output valid, func, pixel_index, pixel_value, dest_col, dest_row, screen_pixel,
        input  ready
    );
    modport sink (
        input  valid, func, pixel_index, pixel_value, dest_col, dest_row, screen_pixel,
        output ready
    );
endinterface

interface sasb_result_if
    import sasb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             write_enable;
    logic [SCR_W-1:0] screen_col;
    logic [SCR_W-1:0] screen_row;
    logic [PIX_W-1:0] out_pixel;

    modport source (
        output valid, write_enable, screen_col, screen_row, out_pixel,
        input  ready
    );
    modport sink (
        input  valid, write_enable, screen_col, screen_row, out_pixel,
        output ready
    );
endinterface

>>> hw/rtl/sasb_ram.sv
module sasb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/sasb_map.sv
module sasb_map
    import sasb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  logic     in_valid,
    input  req_t     req,
    input  cfg_t     cfg,
    output mem_req_t mem,
    output tag_t     tag
);

    logic              a_valid_reg;
    logic              a_func_reg;
    logic [IDX_W-1:0]  a_pidx_reg;
    logic [PIX_W-1:0]  a_pval_reg;
    logic [PROD_W-1:0] a_qx_reg;
    logic [PROD_W-1:0] a_qy_reg;
    logic              a_scale_ok_reg;
    logic              a_on_screen_reg;
    logic [SCR_W-1:0]  a_col_reg;
    logic [SCR_W-1:0]  a_row_reg;
    logic [PIX_W-1:0]  a_dst_reg;

    logic [RECIP_W-1:0] recip;
    logic [SUM_W-1:0]   scol;
    logic [SUM_W-1:0]   srow;
    logic               on_screen;

    logic [OFS_W-1:0]   sx;
    logic [OFS_W-1:0]   sy;
    logic [DIM_W-1:0]   wc;
    logic [DIM_W-1:0]   hc;
    logic               in_range;
    logic [DIM_W-1:0]   sxm;
    logic [2*DIM_W-1:0] lin;

    // input stage: reciprocal multiply and screen position
    always_comb
    begin
        recip = RECIP_TAB[cfg.scale_factor];
        scol  = {cfg.origin_x[POS_W-1], cfg.origin_x} + SUM_W'(req.dest_col);
        srow  = {cfg.origin_y[POS_W-1], cfg.origin_y} + SUM_W'(req.dest_row);
        on_screen = !scol[SUM_W-1] && (32'(scol) < SCREEN_WIDTH)
                 && !srow[SUM_W-1] && (32'(srow) < SCREEN_HEIGHT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_func_reg      <= req.func;
            a_pidx_reg      <= req.pixel_index;
            a_pval_reg      <= req.pixel_value;
            a_qx_reg        <= PROD_W'(req.dest_col) * PROD_W'(recip);
            a_qy_reg        <= PROD_W'(req.dest_row) * PROD_W'(recip);
            a_scale_ok_reg  <= (cfg.scale_factor != '0);
            a_on_screen_reg <= on_screen;
            a_col_reg       <= scol[SCR_W-1:0];
            a_row_reg       <= srow[SCR_W-1:0];
            a_dst_reg       <= req.screen_pixel;
        end
    end

    // address stage: source coordinates, range check, store address
    always_comb
    begin
        sx = a_qx_reg[RECIP_SH +: OFS_W];
        sy = a_qy_reg[RECIP_SH +: OFS_W];
        wc = (32'(cfg.sprite_width) > MAX_SPRITE_W) ? DIM_W'(MAX_SPRITE_W) : cfg.sprite_width;
        hc = (32'(cfg.sprite_height) > MAX_SPRITE_H) ? DIM_W'(MAX_SPRITE_H) : cfg.sprite_height;
        in_range = a_scale_ok_reg && (wc != '0) && (hc != '0)
                && (sx < OFS_W'(wc)) && (sy < OFS_W'(hc));
        sxm = cfg.mirror ? (wc - DIM_W'(1) - sx[DIM_W-1:0]) : sx[DIM_W-1:0];
        lin = (2*DIM_W)'(sy[DIM_W-1:0]) * (2*DIM_W)'(wc) + (2*DIM_W)'(sxm);

        mem.we    = adv && a_valid_reg && (a_func_reg == FUNC_LOAD)
                 && (32'(a_pidx_reg) < STORE_DEPTH);
        mem.waddr = ADDR_W'(a_pidx_reg);
        mem.wdata = a_pval_reg;
        mem.re    = adv;
        mem.raddr = ADDR_W'(lin);

        tag.valid        = a_valid_reg;
        tag.draw         = a_valid_reg && (a_func_reg == FUNC_DRAW) && in_range
                        && a_on_screen_reg;
        tag.screen_col   = a_col_reg;
        tag.screen_row   = a_row_reg;
        tag.screen_pixel = a_dst_reg;
    end

endmodule

>>> hw/rtl/sasb_blend.sv
module sasb_blend
    import sasb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  tag_t             tag,
    input  logic [PIX_W-1:0] src_pixel,
    output logic             valid,
    output logic             write_enable,
    output logic [SCR_W-1:0] screen_col,
    output logic [SCR_W-1:0] screen_row,
    output logic [PIX_W-1:0] out_pixel
);

    logic             b_valid_reg;
    logic             b_draw_reg;
    logic [SCR_W-1:0] b_col_reg;
    logic [SCR_W-1:0] b_row_reg;
    logic [PIX_W-1:0] b_dst_reg;

    logic               c_valid_reg;
    logic               c_we_reg;
    logic               c_opaque_reg;
    logic [3*CH_W-1:0]  c_src_reg;
    logic [MIX_W-1:0]   c_mix_reg [3];
    logic [SCR_W-1:0]   c_col_reg;
    logic [SCR_W-1:0]   c_row_reg;

    logic               o_valid_reg;
    logic               o_we_reg;
    logic [SCR_W-1:0]   o_col_reg;
    logic [SCR_W-1:0]   o_row_reg;
    logic [PIX_W-1:0]   o_pixel_reg;

    logic [CH_W-1:0]    alpha;
    logic [CH_W-1:0]    alpha_inv;
    logic               b_we;
    logic [MIX_W-1:0]   mix [3];
    logic [3*CH_W-1:0]  blended;
    logic [PIX_W-1:0]   pixel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= tag.valid;
            c_valid_reg <= b_valid_reg;
            o_valid_reg <= c_valid_reg;
        end
    end

    // products of source and destination channels
    always_comb
    begin
        alpha     = src_pixel[PIX_W-1 -: CH_W];
        alpha_inv = CH_MAX - alpha;
        b_we      = b_draw_reg && (alpha != '0);
        for (int i = 0; i < 3; i++)
        begin
            mix[i] = MIX_W'(src_pixel[i*CH_W +: CH_W]) * MIX_W'(alpha)
                   + MIX_W'(b_dst_reg[i*CH_W +: CH_W]) * MIX_W'(alpha_inv);
        end
    end

    // divide by 255 and pack; opaque texels pass through, skipped results are zero
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            blended[i*CH_W +: CH_W] = div255(c_mix_reg[i]);
        end
        if (!c_we_reg)
        begin
            pixel_next = '0;
        end
        else if (c_opaque_reg)
        begin
            pixel_next = {ALPHA_FULL, c_src_reg};
        end
        else
        begin
            pixel_next = {ALPHA_FULL, blended};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_draw_reg   <= tag.draw;
            b_col_reg    <= tag.screen_col;
            b_row_reg    <= tag.screen_row;
            b_dst_reg    <= tag.screen_pixel;

            c_we_reg     <= b_we;
            c_opaque_reg <= (alpha >= OPAQUE_LIMIT);
            c_src_reg    <= src_pixel[3*CH_W-1:0];
            for (int i = 0; i < 3; i++)
            begin
                c_mix_reg[i] <= mix[i];
            end
            c_col_reg    <= b_we ? b_col_reg : '0;
            c_row_reg    <= b_we ? b_row_reg : '0;

            o_we_reg     <= c_we_reg;
            o_col_reg    <= c_col_reg;
            o_row_reg    <= c_row_reg;
            o_pixel_reg  <= pixel_next;
        end
    end

    assign valid        = o_valid_reg;
    assign write_enable = o_we_reg;
    assign screen_col   = o_col_reg;
    assign screen_row   = o_row_reg;
    assign out_pixel    = o_pixel_reg;

    a_write_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_we_reg |-> o_pixel_reg[PIX_W-1 -: CH_W] == ALPHA_FULL)
        else $error("written pixel without full alpha");

    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && !o_we_reg |-> o_col_reg == '0 && o_row_reg == '0 && o_pixel_reg == '0)
        else $error("skipped result carries nonzero fields");

    a_write_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_we_reg |->
            32'(o_col_reg) < SCREEN_WIDTH && 32'(o_row_reg) < SCREEN_HEIGHT)
        else $error("write outside the screen");

endmodule

>>> hw/rtl/scaled_alpha_sprite_blit_unit.sv
// channel  side    handshake    payload
// cmd      sink    valid/ready  func, pixel_index, pixel_value, dest_col, dest_row,
//                               screen_pixel
// result   source  valid/ready  write_enable, screen_col, screen_row, out_pixel
// cfg      sink    cfg_we       cfg_index, cfg_data
//
// one request per cycle while results are taken, loads and draws alike, one result per request
// each request passes in order through the input stage with the reciprocal multiply, the
// sprite store read, the channel products and the divide by 255 into the output register
// a result not taken holds the whole pipeline, ready follows the output register
// reset clears valid bits and restores register defaults; sprite store is not cleared
module scaled_alpha_sprite_blit_unit
    import sasb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sasb_cmd_if.sink              cmd,
    sasb_result_if.source         result
);

    cfg_t     cfg_reg;
    req_t     req;
    mem_req_t mem;
    tag_t     tag;
    logic     adv;
    logic     out_valid;
    logic [PIX_W-1:0] src_pixel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.scale_factor  <= SCALE_W'(1);
            cfg_reg.mirror        <= 1'b0;
            cfg_reg.sprite_width  <= DIM_W'(64);
            cfg_reg.sprite_height <= DIM_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORIGIN_X:      cfg_reg.origin_x      <= cfg_data[POS_W-1:0];
                CFG_ORIGIN_Y:      cfg_reg.origin_y      <= cfg_data[POS_W-1:0];
                CFG_SCALE_FACTOR:  cfg_reg.scale_factor  <= cfg_data[SCALE_W-1:0];
                CFG_MIRROR:        cfg_reg.mirror        <= cfg_data[0];
                CFG_SPRITE_WIDTH:  cfg_reg.sprite_width  <= cfg_data[DIM_W-1:0];
                CFG_SPRITE_HEIGHT: cfg_reg.sprite_height <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv       = !out_valid || result.ready;
    assign cmd.ready = adv;

    always_comb
    begin
        req.func         = cmd.func;
        req.pixel_index  = cmd.pixel_index;
        req.pixel_value  = cmd.pixel_value;
        req.dest_col     = cmd.dest_col;
        req.dest_row     = cmd.dest_row;
        req.screen_pixel = cmd.screen_pixel;
    end

    sasb_map u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (cmd.valid),
        .req      (req),
        .cfg      (cfg_reg),
        .mem      (mem),
        .tag      (tag)
    );

    sasb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .re    (mem.re),
        .raddr (mem.raddr),
        .rdata (src_pixel)
    );

    sasb_blend u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .tag          (tag),
        .src_pixel    (src_pixel),
        .valid        (out_valid),
        .write_enable (result.write_enable),
        .screen_col   (result.screen_col),
        .screen_row   (result.screen_row),
        .out_pixel    (result.out_pixel)
    );

    assign result.valid = out_valid;

endmodule

>>> sim/tb_scaled_alpha_sprite_blit_unit.sv
`timescale 1ns / 100ps

module tb_scaled_alpha_sprite_blit_unit;
    import sasb_pkg::*;

    localparam int PIPE_LATENCY   = 3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 200;
    localparam int PHASE_ITEMS    = 80;
    localparam int HOLD_BACKLOG   = 30;
    localparam int OFS_MAX        = (1 << OFS_W) - 1;

    typedef struct packed {
        logic             write_enable;
        logic [SCR_W-1:0] screen_col;
        logic [SCR_W-1:0] screen_row;
        logic [PIX_W-1:0] out_pixel;
    } blit_result_t;

    typedef enum logic [1:0] {TAKE_ALL, TAKE_HALF, TAKE_SPARSE, TAKE_CADENCE} take_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sasb_cmd_if    cmd_ch ();
    sasb_result_if res_ch ();

    scaled_alpha_sprite_blit_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .result    (res_ch)
    );

    logic signed [POS_W-1:0] org_x;
    logic signed [POS_W-1:0] org_y;
    logic [SCALE_W-1:0]      mag;
    logic                    flip;
    logic [DIM_W-1:0]        spr_w;
    logic [DIM_W-1:0]        spr_h;
    logic [PIX_W-1:0]        sprite_mem [STORE_DEPTH];
    bit                      texel_loaded [STORE_DEPTH];

    req_t         pending_reqs [$];
    blit_result_t expected_writes [$];
    req_t         on_bus;

    int issued_reqs = 0;
    int checked_results = 0;
    int errors = 0;
    int holds_wanted = 0;
    int holds_done = 0;
    int burst_left = 1;
    int gap_left = 0;
    int hold_left = 0;
    int mode_left = 0;
    int take_tick = 0;
    int idle_cycles = 0;
    take_mode_t take_mode = TAKE_ALL;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int eff_width();
        return (int'(spr_w) > MAX_SPRITE_W) ? MAX_SPRITE_W : int'(spr_w);
    endfunction

    function automatic int eff_height();
        return (int'(spr_h) > MAX_SPRITE_H) ? MAX_SPRITE_H : int'(spr_h);
    endfunction

    // maps a draw offset to a store address; 0 when the draw is skipped before the read
    function automatic bit locate_texel(input logic [OFS_W-1:0] dcol,
                                        input logic [OFS_W-1:0] drow,
                                        output int addr, output int scol, output int srow);
        int w, h, m, sx, sy, ox, oy;
        w = eff_width();
        h = eff_height();
        m = int'(mag);
        ox = org_x;
        oy = org_y;
        addr = 0;
        scol = 0;
        srow = 0;
        if (m == 0 || w == 0 || h == 0)
            return 1'b0;
        sx = int'(dcol) / m;
        sy = int'(drow) / m;
        if (sx >= w || sy >= h)
            return 1'b0;
        if (flip)
            sx = w - 1 - sx;
        scol = ox + int'(dcol);
        srow = oy + int'(drow);
        if (scol < 0 || scol >= SCREEN_WIDTH || srow < 0 || srow >= SCREEN_HEIGHT)
            return 1'b0;
        addr = (sy * w + sx) % STORE_DEPTH;
        return 1'b1;
    endfunction

    function automatic logic [CH_W-1:0] blend_channel(input logic [CH_W-1:0] s,
                                                      input logic [CH_W-1:0] d,
                                                      input logic [CH_W-1:0] a);
        int si, di, ai, v;
        si = s;
        di = d;
        ai = a;
        v = (si * ai + di * (int'(CH_MAX) - ai)) / int'(CH_MAX);
        return v[CH_W-1:0];
    endfunction

    function automatic blit_result_t apply_request(input req_t r);
        blit_result_t res;
        int addr, scol, srow;
        logic [PIX_W-1:0] src;
        logic [CH_W-1:0] a;
        res = '0;
        if (r.func == FUNC_LOAD)
        begin
            sprite_mem[r.pixel_index] = r.pixel_value;
            return res;
        end
        if (!locate_texel(r.dest_col, r.dest_row, addr, scol, srow))
            return res;
        src = sprite_mem[addr];
        a = src[31:24];
        if (a == '0)
            return res;
        res.write_enable = 1'b1;
        res.screen_col = scol[SCR_W-1:0];
        res.screen_row = srow[SCR_W-1:0];
        if (a >= OPAQUE_LIMIT)
            res.out_pixel = {ALPHA_FULL, src[23:0]};
        else
            res.out_pixel = {ALPHA_FULL,
                             blend_channel(src[23:16], r.screen_pixel[23:16], a),
                             blend_channel(src[15:8], r.screen_pixel[15:8], a),
                             blend_channel(src[7:0], r.screen_pixel[7:0], a)};
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] random_texel();
        logic [PIX_W-1:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0: v[31:24] = '0;
            1, 2: v[31:24] = 8'($urandom_range(250, 255));
            default: v[31:24] = 8'($urandom_range(1, 249));
        endcase
        return v;
    endfunction

    function automatic req_t noise_req();
        logic [95:0] noise;
        noise = {$urandom(), $urandom(), $urandom()};
        return noise[$bits(req_t)-1:0];
    endfunction

    task automatic push_load(input int idx, input logic [PIX_W-1:0] value);
        req_t r;
        r = noise_req();
        r.func = FUNC_LOAD;
        r.pixel_index = IDX_W'(idx);
        r.pixel_value = value;
        pending_reqs.push_back(r);
        texel_loaded[idx] = 1'b1;
    endtask

    // a draw that would read a never-loaded texel gets a load in front of it
    task automatic push_draw(input int dcol, input int drow, input logic [PIX_W-1:0] screen);
        req_t r;
        int addr, scol, srow;
        if (locate_texel(OFS_W'(dcol), OFS_W'(drow), addr, scol, srow) && !texel_loaded[addr])
            push_load(addr, random_texel());
        r = noise_req();
        r.func = FUNC_DRAW;
        r.dest_col = OFS_W'(dcol);
        r.dest_row = OFS_W'(drow);
        r.screen_pixel = screen;
        pending_reqs.push_back(r);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
    endtask

    task automatic program_regs(input int ox, input int oy, input int sc, input int mi,
                                input int sw, input int sh);
        logic [CFG_DATA_W-1:0] junk_a, junk_b;
        logic [CFG_DATA_W-1:0] d_sc, d_mi, d_sw, d_sh;
        junk_a = CFG_DATA_W'($urandom());
        junk_b = CFG_DATA_W'($urandom());
        d_sc = {junk_a[CFG_DATA_W-1:SCALE_W], SCALE_W'(sc)};
        d_mi = {junk_b[CFG_DATA_W-1:1], 1'(mi)};
        d_sw = {junk_a[CFG_DATA_W-1:DIM_W], DIM_W'(sw)};
        d_sh = {junk_b[CFG_DATA_W-1:DIM_W], DIM_W'(sh)};
        write_reg(CFG_ORIGIN_X, CFG_DATA_W'(ox));
        write_reg(CFG_ORIGIN_Y, CFG_DATA_W'(oy));
        write_reg(CFG_SCALE_FACTOR, d_sc);
        write_reg(CFG_MIRROR, d_mi);
        write_reg(CFG_SPRITE_WIDTH, d_sw);
        write_reg(CFG_SPRITE_HEIGHT, d_sh);
        @(posedge clk);
        cfg_we <= 1'b0;
        org_x = CFG_DATA_W'(ox);
        org_y = CFG_DATA_W'(oy);
        mag = d_sc[SCALE_W-1:0];
        flip = d_mi[0];
        spr_w = d_sw[DIM_W-1:0];
        spr_h = d_sh[DIM_W-1:0];
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || issued_reqs != checked_results)
            @(posedge clk);
    endtask

    task automatic random_phase(input bit long_stall);
        int i, w, h, m, span_c, span_r, idx;
        w = eff_width();
        h = eff_height();
        m = int'(mag);
        span_c = (w * m + 2 > OFS_MAX) ? OFS_MAX : w * m + 2;
        span_r = (h * m + 2 > OFS_MAX) ? OFS_MAX : h * m + 2;
        if (long_stall)
            holds_wanted++;
        for (i = 0; i < PHASE_ITEMS; i++)
        begin
            // sender pause mid-phase until everything is answered
            if (i == PHASE_ITEMS / 2)
                wait_drained();
            if ($urandom_range(0, 99) < 25)
            begin
                if ($urandom_range(0, 9) == 0 || w * h == 0)
                    idx = $urandom_range(0, STORE_DEPTH - 1);
                else
                    idx = $urandom_range(0, w * h - 1);
                push_load(idx, random_texel());
            end
            else if ($urandom_range(0, 9) == 0 || m == 0 || w == 0 || h == 0)
                push_draw($urandom_range(0, OFS_MAX), $urandom_range(0, OFS_MAX), $urandom());
            else
                push_draw($urandom_range(0, span_c), $urandom_range(0, span_r), $urandom());
        end
        wait_drained();
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                   input logic [PIX_W-1:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.func <= FUNC_LOAD;
            cmd_ch.pixel_index <= '0;
            cmd_ch.pixel_value <= '0;
            cmd_ch.dest_col <= '0;
            cmd_ch.dest_row <= '0;
            cmd_ch.screen_pixel <= '0;
        end
        else if (!cmd_ch.valid || cmd_ch.ready)
        begin
            if (cmd_ch.valid)
                expected_writes.push_back(apply_request(on_bus));
            if (gap_left > 0)
            begin
                gap_left--;
                cmd_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                on_bus = pending_reqs.pop_front();
                cmd_ch.valid <= 1'b1;
                cmd_ch.func <= on_bus.func;
                cmd_ch.pixel_index <= on_bus.pixel_index;
                cmd_ch.pixel_value <= on_bus.pixel_value;
                cmd_ch.dest_col <= on_bus.dest_col;
                cmd_ch.dest_row <= on_bus.dest_row;
                cmd_ch.screen_pixel <= on_bus.screen_pixel;
                issued_reqs++;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // receiver: stall pattern plus an occasional long hold-off so requests back up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else if (holds_done < holds_wanted && pending_reqs.size() > HOLD_BACKLOG)
        begin
            holds_done++;
            hold_left = LONG_HOLD;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                take_mode = take_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            else
                mode_left--;
            take_tick++;
            case (take_mode)
                TAKE_ALL: res_ch.ready <= 1'b1;
                TAKE_HALF: res_ch.ready <= 1'($urandom_range(0, 1));
                TAKE_SPARSE: res_ch.ready <= ($urandom_range(0, 4) == 0);
                default: res_ch.ready <= (take_tick % 7 < 4);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_writes.size() == 0)
                report_mismatch("unexpected result", res_ch.out_pixel, '0);
            else
            begin
                blit_result_t want;
                want = expected_writes.pop_front();
                if (res_ch.write_enable !== want.write_enable)
                    report_mismatch("write_enable", PIX_W'(res_ch.write_enable),
                                    PIX_W'(want.write_enable));
                if (res_ch.screen_col !== want.screen_col)
                    report_mismatch("screen_col", PIX_W'(res_ch.screen_col),
                                    PIX_W'(want.screen_col));
                if (res_ch.screen_row !== want.screen_row)
                    report_mismatch("screen_row", PIX_W'(res_ch.screen_row),
                                    PIX_W'(want.screen_row));
                if (res_ch.out_pixel !== want.out_pixel)
                    report_mismatch("out_pixel", res_ch.out_pixel, want.out_pixel);
                checked_results++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                idle_cycles++;
        end
    end

    initial
    begin
        int k, ox, oy, sc, mi, sw, sh, r;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        org_x = '0;
        org_y = '0;
        mag = SCALE_W'(1);
        flip = 1'b0;
        spr_w = DIM_W'(MAX_SPRITE_W);
        spr_h = DIM_W'(MAX_SPRITE_H);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: alpha zero, opaque, threshold, blends, corners, out of sprite
        push_load(0, 32'h0012_3456);
        push_load(1, 32'hFFFF_FFFF);
        push_load(2, 32'hFA10_2030);
        push_load(3, 32'hF9FF_FFFF);
        push_load(4, 32'h01AB_CDEF);
        push_load(63, 32'h80FF_00FF);
        push_load(64, 32'h7F00_FF00);
        push_load(STORE_DEPTH - 1, 32'hFE00_0000);
        push_draw(0, 0, 32'hFFFF_FFFF);
        push_draw(1, 0, 32'h0000_0000);
        push_draw(2, 0, 32'h1234_5678);
        push_draw(3, 0, 32'h0000_0000);
        push_draw(4, 0, 32'hFFFF_FFFF);
        push_draw(63, 0, 32'hFF80_8080);
        push_draw(0, 1, 32'h00FF_FFFF);
        push_draw(63, 63, 32'hAAAA_AAAA);
        push_draw(64, 0, 32'h5555_5555);
        push_draw(0, 64, 32'h5555_5555);
        push_draw(OFS_MAX, OFS_MAX, $urandom());
        wait_drained();
        repeat (PIPE_LATENCY + 2) @(posedge clk);

        program_regs(-1024, -1024, 15, 1, 127, 127);
        random_phase(1'b0);
        program_regs(1023, 1023, 0, 0, 0, 0);
        random_phase(1'b0);
        program_regs(-5, -3, 8, 1, 64, 64);
        random_phase(1'b1);
        program_regs(600, 440, 1, 0, 1, 1);
        random_phase(1'b0);
        program_regs(0, 0, 2, 1, 64, 0);
        random_phase(1'b0);
        program_regs(100, 50, 3, 0, 0, 17);
        random_phase(1'b0);

        for (k = 0; k < 6; k++)
        begin
            ox = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2047)) - 1024
                                             : int'($urandom_range(0, 680)) - 60;
            oy = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2047)) - 1024
                                             : int'($urandom_range(0, 520)) - 60;
            r = $urandom_range(0, 9);
            sc = (r == 0) ? 0 : (r == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8);
            mi = $urandom_range(0, 1);
            r = $urandom_range(0, 9);
            sw = (r == 0) ? 0 : (r == 1) ? $urandom_range(65, 127) : $urandom_range(1, 64);
            r = $urandom_range(0, 9);
            sh = (r == 0) ? 0 : (r == 1) ? $urandom_range(65, 127) : $urandom_range(1, 64);
            program_regs(ox, oy, sc, mi, sw, sh);
            random_phase(k == 3);
        end

        wait_drained();
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
